[hdl/prm_pkg.sv]
// Shared types, widths and codes for the periodic release monitor.
// No dependencies; compiled first.
package prm_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned PeriodW = 24;
  localparam int unsigned TolW    = 24;
  localparam int unsigned DlW     = 32;
  localparam int unsigned ExpW    = 34;
  localparam int unsigned JitW    = 35;
  localparam int unsigned CntW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned DivSteps = TimeW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WAKE  = 2'd1,
    CMD_DONE  = 2'd2
  } prm_cmd_e;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_LATE = 2'd1,
    FAULT_MISS = 2'd2
  } prm_fault_e;

  localparam logic [CfgIdxW-1:0] CFG_PERIOD   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TOL      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEADLINE = 2'd2;

  typedef struct packed {
    logic               start;
    logic [TimeW-1:0]   dividend;
    logic [PeriodW-1:0] divisor;
  } prm_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [PeriodW-1:0] rem;
  } prm_div_rsp_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    return (&c) ? c : c + CntW'(1);
  endfunction

endpackage

[hdl/prm_if.sv]
// Handshake channels of the periodic release monitor: event input, result
// output and register write. Depends on prm_pkg.
interface prm_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic [prm_pkg::TimeW-1:0]   time_value;
  modport source (output valid, cmd, time_value, input ready);
  modport sink   (input valid, cmd, time_value, output ready);
endinterface

interface prm_out_if;
  logic                              valid;
  logic                              ready;
  logic                              skipped;
  logic                              late;
  logic                              deadline_missed;
  logic signed [prm_pkg::JitW-1:0]   wake_jitter;
  logic signed [prm_pkg::JitW-1:0]   jitter_min;
  logic signed [prm_pkg::JitW-1:0]   jitter_max;
  logic [prm_pkg::CntW-1:0]          sample_count;
  logic [prm_pkg::CntW-1:0]          late_count;
  logic [prm_pkg::CntW-1:0]          skip_count;
  logic [prm_pkg::CntW-1:0]          miss_count;
  logic [1:0]                        last_fault;
  logic [prm_pkg::ExpW-1:0]          expected_next;
  modport source (output valid, skipped, late, deadline_missed, wake_jitter, jitter_min,
                  jitter_max, sample_count, late_count, skip_count, miss_count,
                  last_fault, expected_next, input ready);
  modport sink   (input valid, skipped, late, deadline_missed, wake_jitter, jitter_min,
                  jitter_max, sample_count, late_count, skip_count, miss_count,
                  last_fault, expected_next, output ready);
endinterface

interface prm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [prm_pkg::CfgIdxW-1:0]   index;
  logic [prm_pkg::CfgDatW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/periodic_release_monitor.sv]
// Periodic release monitor: decodes start, wake and completion words, keeps
// the jitter statistics and realigns the expected tick. Depends on prm_pkg,
// prm_if and prm_rem_unit.
// Flow: one word at a time; the next word is accepted once the result of the
//   last is registered, which waits while an earlier result is still unread.
//   A skipped wake also waits for the 32-step serial remainder unit.
// Reset: asynchronous, active low; registers, statistics and expected tick clear.
module periodic_release_monitor (
  input logic       clk_i,
  input logic       rst_ni,
  prm_in_if.sink    in_i,
  prm_out_if.source out_o,
  prm_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [prm_pkg::PeriodW-1:0] period_q;
  logic [prm_pkg::TolW-1:0]    tol_q;
  logic [prm_pkg::DlW-1:0]     deadline_q;

  logic [1:0]                  cmd_q;
  logic [prm_pkg::TimeW-1:0]   t_q;
  logic                        skip_q, skip_d;
  logic [prm_pkg::PeriodW-1:0] rem_q;

  logic [prm_pkg::ExpW-1:0]        exp_q, exp_d;
  logic signed [prm_pkg::JitW-1:0] min_q, min_d;
  logic signed [prm_pkg::JitW-1:0] max_q, max_d;
  logic [prm_pkg::CntW-1:0]        samples_q, samples_d;
  logic [prm_pkg::CntW-1:0]        lates_q, lates_d;
  logic [prm_pkg::CntW-1:0]        skips_q, skips_d;
  logic [prm_pkg::CntW-1:0]        misses_q, misses_d;
  logic [1:0]                      fault_q, fault_d;

  logic                            out_valid_q;
  logic                            f_skip_q, f_skip_d;
  logic                            f_late_q, f_late_d;
  logic                            f_miss_q, f_miss_d;
  logic signed [prm_pkg::JitW-1:0] jit_q, jit_d;

  prm_pkg::prm_div_req_t div_req;
  prm_pkg::prm_div_rsp_t div_rsp;

  logic                            accept;
  logic                            finish;
  logic signed [prm_pkg::JitW-1:0] jit_calc;
  logic [prm_pkg::JitW-1:0]        late_bound;
  logic [prm_pkg::JitW-1:0]        next_sum;
  logic [prm_pkg::ExpW-1:0]        realigned;
  logic                            wake_past;

  assign accept = in_i.valid && in_i.ready;
  assign finish = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign wake_past  = {2'b00, t_q} > exp_q;
  assign jit_calc   = $signed({3'b000, t_q}) - $signed({1'b0, exp_q});
  assign late_bound = {1'b0, exp_q} + {11'd0, tol_q};
  assign next_sum   = {1'b0, exp_q} + {11'd0, period_q};
  assign realigned  = {2'b00, t_q} - {10'd0, rem_q} + {10'd0, period_q};

  assign div_req.start    = (state_q == S_EVAL) && skip_d;
  assign div_req.dividend = t_q;
  assign div_req.divisor  = period_q;

  prm_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign skip_d = (prm_pkg::prm_cmd_e'(cmd_q) == prm_pkg::CMD_WAKE) && (period_q != '0)
                  && wake_past;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EVAL;
      S_EVAL: state_d = skip_d ? S_DIV : S_FIN;
      S_DIV:  if (div_rsp.done) state_d = S_FIN;
      S_FIN:  if (finish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // statistics update at the end of each word
  always_comb begin
    exp_d     = exp_q;
    min_d     = min_q;
    max_d     = max_q;
    samples_d = samples_q;
    lates_d   = lates_q;
    skips_d   = skips_q;
    misses_d  = misses_q;
    fault_d   = fault_q;
    f_skip_d  = 1'b0;
    f_late_d  = 1'b0;
    f_miss_d  = 1'b0;
    jit_d     = '0;
    case (prm_pkg::prm_cmd_e'(cmd_q))
      prm_pkg::CMD_START: begin
        exp_d     = {2'b00, t_q};
        min_d     = '0;
        max_d     = '0;
        samples_d = '0;
        lates_d   = '0;
        skips_d   = '0;
        misses_d  = '0;
        fault_d   = prm_pkg::FAULT_NONE;
      end
      prm_pkg::CMD_WAKE: begin
        if (period_q != '0) begin
          if (skip_q) begin
            exp_d    = realigned;
            skips_d  = prm_pkg::sat_inc(skips_q);
            fault_d  = prm_pkg::FAULT_LATE;
            f_skip_d = 1'b1;
          end else begin
            jit_d = jit_calc;
            if ((samples_q == '0) || (jit_calc < min_q)) min_d = jit_calc;
            if (jit_calc > max_q) max_d = jit_calc;
            samples_d = prm_pkg::sat_inc(samples_q);
            if ({3'b000, t_q} > late_bound) begin
              lates_d  = prm_pkg::sat_inc(lates_q);
              fault_d  = prm_pkg::FAULT_LATE;
              f_late_d = 1'b1;
            end else begin
              exp_d = next_sum[prm_pkg::ExpW] ? '1 : next_sum[prm_pkg::ExpW-1:0];
            end
          end
        end
      end
      prm_pkg::CMD_DONE: begin
        if (t_q > deadline_q) begin
          misses_d = prm_pkg::sat_inc(misses_q);
          fault_d  = prm_pkg::FAULT_MISS;
          f_miss_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= '0;
      tol_q       <= '0;
      deadline_q  <= '0;
      exp_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      samples_q   <= '0;
      lates_q     <= '0;
      skips_q     <= '0;
      misses_q    <= '0;
      fault_q     <= prm_pkg::FAULT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          prm_pkg::CFG_PERIOD:   period_q   <= cfg_i.data[prm_pkg::PeriodW-1:0];
          prm_pkg::CFG_TOL:      tol_q      <= cfg_i.data[prm_pkg::TolW-1:0];
          prm_pkg::CFG_DEADLINE: deadline_q <= cfg_i.data[prm_pkg::DlW-1:0];
          default: ;
        endcase
      end
      if (out_o.valid && out_o.ready) out_valid_q <= 1'b0;
      if (finish) begin
        out_valid_q <= 1'b1;
        exp_q       <= exp_d;
        min_q       <= min_d;
        max_q       <= max_d;
        samples_q   <= samples_d;
        lates_q     <= lates_d;
        skips_q     <= skips_d;
        misses_q    <= misses_d;
        fault_q     <= fault_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_i.cmd;
      t_q   <= in_i.time_value;
    end
    if (state_q == S_EVAL) skip_q <= skip_d;
    if (div_rsp.done) rem_q <= div_rsp.rem;
    if (finish) begin
      f_skip_q <= f_skip_d;
      f_late_q <= f_late_d;
      f_miss_q <= f_miss_d;
      jit_q    <= jit_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.skipped         = f_skip_q;
  assign out_o.late            = f_late_q;
  assign out_o.deadline_missed = f_miss_q;
  assign out_o.wake_jitter     = jit_q;
  assign out_o.jitter_min      = min_q;
  assign out_o.jitter_max      = max_q;
  assign out_o.sample_count    = samples_q;
  assign out_o.late_count      = lates_q;
  assign out_o.skip_count      = skips_q;
  assign out_o.miss_count      = misses_q;
  assign out_o.last_fault      = fault_q;
  assign out_o.expected_next   = exp_q;

  a_div_needs_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (period_q != '0)) else $error("divide with zero period");
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($countones({f_skip_q, f_late_q, f_miss_q}) <= 1))
    else $error("more than one event flag");
  a_skip_moves_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && f_skip_d) |-> (realigned > {2'b00, t_q}))
    else $error("realigned tick not past wake tick");
  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN)) else $error("result without finish");

endmodule

[hdl/prm_rem_unit.sv]
// Bit-serial restoring divider returning the remainder of a tick by the period.
// One quotient bit per cycle through a single subtractor. Depends on prm_pkg.
module prm_rem_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prm_pkg::prm_div_req_t req_i,
  output prm_pkg::prm_div_rsp_t rsp_o
);

  logic [prm_pkg::TimeW-1:0]   dvd_q, dvd_d;
  logic [prm_pkg::PeriodW-1:0] div_q, div_d;
  logic [prm_pkg::PeriodW-1:0] rem_q, rem_d;
  logic [prm_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  logic [prm_pkg::PeriodW:0]   shifted;
  logic [prm_pkg::PeriodW+1:0] trial;

  assign shifted = {rem_q, dvd_q[prm_pkg::TimeW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, div_q};

  always_comb begin
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start && !busy_q) begin
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = prm_pkg::DivCntW'(prm_pkg::DivSteps - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[prm_pkg::TimeW-2:0], 1'b0};
      rem_d = trial[prm_pkg::PeriodW+1] ? shifted[prm_pkg::PeriodW-1:0]
                                        : trial[prm_pkg::PeriodW-1:0];
      cnt_d = cnt_q - prm_pkg::DivCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("remainder done without a running divide");
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q)) else $error("remainder not below divisor");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> (busy_q || done_q)) else $error("divide dropped before completion");

endmodule

[dv/periodic_release_monitor_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for periodic_release_monitor: start, wake and completion words
// with random gaps and stalls, checked field by field against an in-bench predictor.
// Depends on prm_pkg, prm_if and the monitor RTL.
module periodic_release_monitor_tb;
  import prm_pkg::*;

  localparam logic [1:0]         CMD_NOP     = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPARE   = 2'd3;
  localparam int unsigned        IdleLimit   = 2000;
  localparam int unsigned        DrainCycles = 40;
  localparam int unsigned        NumStats    = 12;
  localparam logic [ExpW-1:0]    TickMax     = '1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [TimeW-1:0] tval;
  } event_word_t;

  typedef struct packed {
    logic                   skipped;
    logic                   late;
    logic                   missed;
    logic signed [JitW-1:0] jitter;
    logic signed [JitW-1:0] jit_min;
    logic signed [JitW-1:0] jit_max;
    logic [CntW-1:0]        samples;
    logic [CntW-1:0]        lates;
    logic [CntW-1:0]        skips;
    logic [CntW-1:0]        misses;
    logic [1:0]             fault;
    logic [ExpW-1:0]        next_tick;
  } release_stats_t;

  logic clk = 1'b0;
  logic rst_n;

  prm_in_if  in_if ();
  prm_out_if out_if ();
  prm_cfg_if cfg_if ();

  periodic_release_monitor dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of registers and statistics
  logic [PeriodW-1:0]     period_q;
  logic [TolW-1:0]        tol_q;
  logic [DlW-1:0]         dl_q;
  logic [ExpW-1:0]        next_tick;
  logic signed [JitW-1:0] jit_min_q;
  logic signed [JitW-1:0] jit_max_q;
  logic [CntW-1:0]        n_samples;
  logic [CntW-1:0]        n_lates;
  logic [CntW-1:0]        n_skips;
  logic [CntW-1:0]        n_misses;
  logic [1:0]             fault_q;

  event_word_t    pending_words [$];
  release_stats_t expected_stats [$];
  int unsigned    issued_words   = 0;
  int unsigned    accepted_words = 0;
  int unsigned    error_count    = 0;
  int unsigned    idle_cycles    = 0;
  int unsigned    in_wait        = 0;
  int unsigned    out_wait       = 0;
  logic           in_fire        = 1'b0;
  logic           out_fire       = 1'b0;
  logic           gaps_on        = 1'b1;
  logic           stalls_on      = 1'b1;

  string stat_name [NumStats] = '{"skipped", "late", "deadline_missed", "wake_jitter",
                                  "jitter_min", "jitter_max", "sample_count", "late_count",
                                  "skip_count", "miss_count", "last_fault", "expected_next"};

  function automatic logic [CntW-1:0] bump_sat(input logic [CntW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic void predict_release(input logic [1:0] cmd, input logic [TimeW-1:0] t);
    release_stats_t         r;
    logic signed [JitW-1:0] jit;
    logic [63:0]            sum;
    r   = '0;
    jit = '0;
    if (cmd == CMD_START) begin
      jit_min_q = '0;
      jit_max_q = '0;
      n_samples = '0;
      n_lates   = '0;
      n_skips   = '0;
      n_misses  = '0;
      fault_q   = FAULT_NONE;
      next_tick = ExpW'(t);
    end else if (cmd == CMD_WAKE && period_q != '0) begin
      if (ExpW'(t) > next_tick) begin
        // realign to the next period multiple past the wake
        sum       = (64'(t) / 64'(period_q) + 64'd1) * 64'(period_q);
        next_tick = sum[ExpW-1:0];
        n_skips   = bump_sat(n_skips);
        fault_q   = FAULT_LATE;
        r.skipped = 1'b1;
      end else begin
        jit = $signed({3'b000, t}) - $signed({1'b0, next_tick});
        if (n_samples == '0 || jit < jit_min_q) jit_min_q = jit;
        if (jit > jit_max_q) jit_max_q = jit;
        n_samples = bump_sat(n_samples);
        if (64'(t) > 64'(next_tick) + 64'(tol_q)) begin
          n_lates = bump_sat(n_lates);
          fault_q = FAULT_LATE;
          r.late  = 1'b1;
        end else begin
          sum       = 64'(next_tick) + 64'(period_q);
          next_tick = (sum > 64'(TickMax)) ? TickMax : sum[ExpW-1:0];
        end
      end
    end else if (cmd == CMD_DONE && t > dl_q) begin
      n_misses = bump_sat(n_misses);
      fault_q  = FAULT_MISS;
      r.missed = 1'b1;
    end
    r.jitter    = jit;
    r.jit_min   = jit_min_q;
    r.jit_max   = jit_max_q;
    r.samples   = n_samples;
    r.lates     = n_lates;
    r.skips     = n_skips;
    r.misses    = n_misses;
    r.fault     = fault_q;
    r.next_tick = next_tick;
    expected_stats.push_back(r);
  endfunction

  // event word driver
  always @(negedge clk) begin
    event_word_t w;
    if (rst_n && (in_fire || !in_if.valid)) begin
      if (in_fire) in_wait = gaps_on ? $urandom_range(0, 6) : 0;
      if (in_wait != 0 || pending_words.size() == 0) begin
        in_if.valid <= 1'b0;
        if (in_wait != 0) in_wait--;
      end else begin
        w = pending_words.pop_front();
        in_if.valid      <= 1'b1;
        in_if.cmd        <= w.cmd;
        in_if.time_value <= w.tval;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) out_wait = stalls_on ? $urandom_range(0, 6) : 0;
      if (out_wait != 0) begin
        out_if.ready <= 1'b0;
        out_wait--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // monitor: register writes, accepted words, result check
  always @(posedge clk) begin
    release_stats_t want;
    logic [63:0]    want_f [NumStats];
    logic [63:0]    got_f [NumStats];
    in_fire  <= rst_n && in_if.valid && in_if.ready;
    out_fire <= rst_n && out_if.valid && out_if.ready;
    if (!rst_n) begin
      period_q  = '0;
      tol_q     = '0;
      dl_q      = '0;
      next_tick = '0;
      jit_min_q = '0;
      jit_max_q = '0;
      n_samples = '0;
      n_lates   = '0;
      n_skips   = '0;
      n_misses  = '0;
      fault_q   = FAULT_NONE;
      expected_stats.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_PERIOD:   period_q = cfg_if.data[PeriodW-1:0];
          CFG_TOL:      tol_q    = cfg_if.data[TolW-1:0];
          CFG_DEADLINE: dl_q     = cfg_if.data[DlW-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        predict_release(in_if.cmd, in_if.time_value);
        accepted_words++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_stats.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          error_count++;
        end else begin
          want   = expected_stats.pop_front();
          want_f = '{64'(want.skipped), 64'(want.late), 64'(want.missed),
                     64'({want.jitter}), 64'({want.jit_min}), 64'({want.jit_max}),
                     64'(want.samples), 64'(want.lates), 64'(want.skips),
                     64'(want.misses), 64'(want.fault), 64'(want.next_tick)};
          got_f  = '{64'(out_if.skipped), 64'(out_if.late), 64'(out_if.deadline_missed),
                     64'({out_if.wake_jitter}), 64'({out_if.jitter_min}),
                     64'({out_if.jitter_max}), 64'(out_if.sample_count),
                     64'(out_if.late_count), 64'(out_if.skip_count),
                     64'(out_if.miss_count), 64'(out_if.last_fault),
                     64'(out_if.expected_next)};
          for (int k = 0; k < NumStats; k++) begin
            if (got_f[k] !== want_f[k]) begin
              $display("%0t: %s expected %h got %h", $time, stat_name[k], want_f[k],
                       got_f[k]);
              error_count++;
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("periodic_release_monitor regression: fail");
      $finish;
    end
  end

  task automatic push_word(input logic [1:0] cmd, input logic [TimeW-1:0] tval);
    pending_words.push_back(event_word_t'{cmd, tval});
    issued_words++;
  endtask

  task automatic wait_idle;
    while (accepted_words != issued_words || expected_stats.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // mostly well-formed release trains: wakes on or just before the boundary,
  // some overruns, completions around the deadline, plus noise
  task automatic run_phase(input int unsigned n_words);
    logic [63:0]      guess;
    logic [63:0]      per;
    logic [63:0]      tt;
    logic [TimeW-1:0] t;
    logic [1:0]       cmd;
    int unsigned      pick;
    per = 64'(period_q);
    t   = $urandom_range(0, 32'h00FF_FFFF);
    push_word(CMD_START, t);
    guess = 64'(t);
    repeat (n_words) begin
      pick = $urandom_range(0, 99);
      cmd  = CMD_WAKE;
      if (pick < 8) begin
        cmd = CMD_START;
        t   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
      end else if (pick < 63) begin
        tt = 64'($urandom_range(0, 32'(per / 4 + 1)));
        if (guess > 64'hFFFF_FFFF) t = $urandom;
        else t = (tt > guess) ? '0 : TimeW'(guess - tt);
      end else if (pick < 75) begin
        tt = guess + 64'($urandom_range(1, 32'(3 * per + 1)));
        t  = (tt > 64'hFFFF_FFFF) ? '1 : TimeW'(tt);
      end else if (pick < 90) begin
        cmd = CMD_DONE;
        if ($urandom_range(0, 1) == 0) begin
          t = $urandom;
        end else begin
          tt = 64'(dl_q) + 64'($urandom_range(0, 4));
          if (tt < 2) t = '0;
          else t = (tt - 2 > 64'hFFFF_FFFF) ? '1 : TimeW'(tt - 2);
        end
      end else if (pick < 95) begin
        cmd = CMD_NOP;
        t   = $urandom;
      end else begin
        t = $urandom;
      end
      if (cmd == CMD_START) guess = 64'(t);
      else if (cmd == CMD_WAKE && per != 0)
        guess = (64'(t) > guess) ? (64'(t) / per + 1) * per : guess + per;
      push_word(cmd, t);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_START;
    in_if.time_value = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_PERIOD;
    cfg_if.data      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero period, zero deadline out of reset
    push_word(CMD_WAKE, 32'd5);
    push_word(CMD_NOP, 32'hDEAD_BEEF);
    push_word(CMD_DONE, 32'd0);
    push_word(CMD_DONE, 32'd1);

    write_reg(CFG_PERIOD, 32'd100);
    write_reg(CFG_TOL, 32'd10);
    write_reg(CFG_DEADLINE, 32'd1000);
    push_word(CMD_START, 32'd1000);
    push_word(CMD_WAKE, 32'd995);
    push_word(CMD_WAKE, 32'd1100);
    push_word(CMD_WAKE, 32'd1150);
    push_word(CMD_WAKE, 32'd5003);
    push_word(CMD_WAKE, 32'd0);
    push_word(CMD_DONE, 32'd1000);
    push_word(CMD_DONE, 32'd1001);
    push_word(CMD_DONE, '1);
    push_word(CMD_NOP, 32'd0);
    push_word(CMD_START, '1);
    push_word(CMD_WAKE, '1);
    push_word(CMD_START, 32'd0);
    push_word(CMD_WAKE, '1);
    push_word(CMD_WAKE, 32'd0);

    write_reg(CFG_PERIOD, '1);
    write_reg(CFG_TOL, '1);
    write_reg(CFG_DEADLINE, '1);
    write_reg(CFG_SPARE, 32'h5A5A_A5A5);
    push_word(CMD_DONE, '1);
    push_word(CMD_START, '1);
    push_word(CMD_WAKE, '1);
    push_word(CMD_WAKE, 32'd0);

    for (int p = 0; p < 7; p++) begin
      gaps_on   = (p != 1) && ($urandom_range(0, 3) != 0);
      stalls_on = (p != 1) && ($urandom_range(0, 3) != 0);
      case (p)
        0: begin
          write_reg(CFG_PERIOD, $urandom_range(1, 50));
          write_reg(CFG_TOL, $urandom_range(0, 8));
          write_reg(CFG_DEADLINE, $urandom_range(0, 500));
        end
        1: begin
          write_reg(CFG_PERIOD, 32'd1);
          write_reg(CFG_TOL, 32'd0);
          write_reg(CFG_DEADLINE, 32'd0);
        end
        2: begin
          write_reg(CFG_PERIOD, 32'd0);
          write_reg(CFG_TOL, $urandom);
          write_reg(CFG_DEADLINE, '1);
        end
        3: begin
          write_reg(CFG_PERIOD, '1);
          write_reg(CFG_TOL, '1);
          write_reg(CFG_DEADLINE, $urandom);
        end
        4: begin
          write_reg(CFG_PERIOD, $urandom);
          write_reg(CFG_TOL, $urandom);
          write_reg(CFG_DEADLINE, $urandom);
          write_reg(CFG_SPARE, $urandom);
        end
        5: begin
          write_reg(CFG_PERIOD, 32'($urandom_range(1, 1000)) | ($urandom << 24));
          write_reg(CFG_TOL, $urandom_range(0, 50) | ($urandom << 24));
          write_reg(CFG_DEADLINE, $urandom_range(0, 1000));
        end
        default: begin
          write_reg(CFG_PERIOD, $urandom_range(2, 4096));
          write_reg(CFG_TOL, $urandom_range(0, 100));
          write_reg(CFG_DEADLINE, $urandom_range(0, 100000));
        end
      endcase
      run_phase(55 + $urandom_range(0, 10));
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("periodic_release_monitor regression: pass");
    end else begin
      $display("periodic_release_monitor regression: fail");
    end
    $finish;
  end

endmodule

[periodic_release_monitor.f]
hdl/prm_pkg.sv
hdl/prm_if.sv
hdl/prm_rem_unit.sv
hdl/periodic_release_monitor.sv
dv/periodic_release_monitor_tb.sv
